### hw/rtl/assert_macros.svh
// assert_macros.svh: concurrent assertion macros shared by the RTL.
// Needs clk_i and rst_ni in the scope of the user; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// clocked check, off while reset is low
`define ASSERT_P(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: check failed");
// clocked check, also active during reset
`define ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: check failed");
`else
`define ASSERT_P(lbl, prop)
`define ASSERT_NR(lbl, prop)
`endif
`endif

### hw/rtl/rlde_pkg.sv
// rlde_pkg: widths, codes and constants of the radial log-density evaluator.
// No dependencies.
package rlde_pkg;

  localparam int unsigned RLDE_TABLE_DEPTH = 256;

  localparam int unsigned R_W        = 32;
  localparam int unsigned LD_W       = 48;
  localparam int unsigned ST_W       = 2;
  localparam int unsigned TIDX_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned MUL_W      = 32;

  typedef enum logic [2:0] {
    MODE_UNSET   = 3'd0,
    MODE_GAUSS   = 3'd1,
    MODE_UNIFORM = 3'd2,
    MODE_POWER   = 3'd3,
    MODE_TPOWER  = 3'd4,
    MODE_TABLE   = 3'd5,
    MODE_TGAUSS  = 3'd6
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE          = 3'd0,
    CFG_DIMENSION     = 3'd1,
    CFG_LOG_CONSTANT  = 3'd2,
    CFG_POWER_EXP     = 3'd3,
    CFG_LOWER_BOUND   = 3'd4,
    CFG_UPPER_BOUND   = 3'd5,
    CFG_TABLE_ENTRIES = 3'd6
  } cfg_idx_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_UNSET   = 2'd2
  } status_e;

  typedef enum logic {
    REQ_EVAL  = 1'b0,
    REQ_WRITE = 1'b1
  } req_e;

  // which term the shared multiplier is working on
  typedef enum logic [1:0] {
    PH_GAUSS = 2'd0,
    PH_POW   = 2'd1,
    PH_TABR  = 2'd2,
    PH_TABW  = 2'd3
  } phase_e;

  localparam logic [R_W-1:0]         ONE_Q24 = 32'h0100_0000;
  localparam logic [MUL_W-1:0]       LN2_Q28 = 32'd186065279;
  localparam logic signed [LD_W-1:0] LD_MAX  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [LD_W-1:0] LD_MIN  = 48'sh8000_0000_0000;

endpackage

### hw/rtl/rlde_req_if.sv
// rlde_req_if: request channel (evaluate a radius or write a table entry).
// Depends on rlde_pkg for field widths.
interface rlde_req_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [rlde_pkg::R_W-1:0]    radius;
  logic [rlde_pkg::TIDX_W-1:0] table_index;
  logic [rlde_pkg::R_W-1:0]    table_value;

  modport source (output valid, req_type, radius, table_index, table_value, input ready);
  modport sink (input valid, req_type, radius, table_index, table_value, output ready);
endinterface

### hw/rtl/rlde_res_if.sv
// rlde_res_if: result channel (log density and status).
// Depends on rlde_pkg for field widths.
interface rlde_res_if;
  logic                             valid;
  logic                             ready;
  logic signed [rlde_pkg::LD_W-1:0] log_density;
  logic [rlde_pkg::ST_W-1:0]        status;

  modport source (output valid, log_density, status, input ready);
  modport sink (input valid, log_density, status, output ready);
endinterface

### hw/rtl/rlde_cfg_if.sv
// rlde_cfg_if: configuration write channel (register index and data).
// Depends on rlde_pkg for field widths.
interface rlde_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rlde_pkg::CFG_IDX_W-1:0]  index;
  logic [rlde_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hw/rtl/rlde_mul.sv
// rlde_mul: shared unsigned multiplier with a registered product.
// Depends on rlde_pkg for the operand width.
module rlde_mul (
  input  logic                           clk_i,
  input  logic                           en_i,
  input  logic [rlde_pkg::MUL_W-1:0]     a_i,
  input  logic [rlde_pkg::MUL_W-1:0]     b_i,
  output logic [2*rlde_pkg::MUL_W-1:0]   prod_o
);
  import rlde_pkg::*;

  logic [2*MUL_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= a_i * b_i;
    end
  end

  assign prod_o = prod_q;

endmodule

### hw/rtl/radial_log_density_eval.sv
// radial_log_density_eval: top level; sequencer, radius table and config registers.
// Depends on rlde_pkg, the rlde_*_if interfaces, rlde_mul and assert_macros.svh.
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+------------------------------------------
//  cfg_i   | in  | valid/ready  | index, data (register write)
//  req_i   | in  | valid/ready  | req_type, radius, table_index, table_value
//  res_o   | out | valid/ready  | log_density, status
//
// A table write gives no result word. An evaluation runs on one
// 32x32 multiplier under the sequencer: Gaussian modes square the radius,
// uniform or unset modes use no multiply, power modes normalize, take 28
// squarings and two split multiplies, and table mode takes up to 8 search
// steps and two logarithms.
// Reset clears control state only; table entries are undefined until written.
// A finished word waits in the output register; the next request is taken
// while it waits, and the sequencer holds at its end until the register frees.
`include "assert_macros.svh"
module radial_log_density_eval #(
  parameter int unsigned TABLE_DEPTH = rlde_pkg::RLDE_TABLE_DEPTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  rlde_cfg_if.sink   cfg_i,
  rlde_req_if.sink   req_i,
  rlde_res_if.source res_o
);
  import rlde_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [4:0]  SQ_STEPS = 5'd28;
  localparam logic signed [49:0] VMAX = 50'(LD_MAX);
  localparam logic signed [49:0] VMIN = 50'(LD_MIN);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DECIDE = 5'd1;
  localparam logic [4:0] S_COEF   = 5'd2;
  localparam logic [4:0] S_HSQ    = 5'd3;
  localparam logic [4:0] S_HSQ2   = 5'd4;
  localparam logic [4:0] S_TCHK   = 5'd5;
  localparam logic [4:0] S_TSRCH  = 5'd6;
  localparam logic [4:0] S_TCMP   = 5'd7;
  localparam logic [4:0] S_TLO    = 5'd8;
  localparam logic [4:0] S_TW     = 5'd9;
  localparam logic [4:0] S_TW2    = 5'd10;
  localparam logic [4:0] S_NORM   = 5'd11;
  localparam logic [4:0] S_SQ     = 5'd12;
  localparam logic [4:0] S_LNPREP = 5'd13;
  localparam logic [4:0] S_MLO    = 5'd14;
  localparam logic [4:0] S_MHI    = 5'd15;
  localparam logic [4:0] S_MSUM   = 5'd16;
  localparam logic [4:0] S_ROUND  = 5'd17;
  localparam logic [4:0] S_TERM   = 5'd18;
  localparam logic [4:0] S_ACC    = 5'd19;
  localparam logic [4:0] S_DONE   = 5'd20;

  // configuration registers
  logic [2:0]  mode_q;
  logic [10:0] dim_q;
  logic [47:0] logc_q;
  logic [31:0] pexp_q, lbound_q, ubound_q;
  logic [7:0]  tentries_q;

  // sequencer state
  logic [4:0]  state_q, state_d;
  logic [31:0] r_q, r_d;
  logic signed [49:0] val_q, val_d;
  logic [1:0]  status_q, status_d;
  logic        pinf_q, pinf_d;
  phase_e      ph_q, ph_d;
  logic [39:0] x_q, x_d;
  logic [5:0]  p_q, p_d;
  logic [27:0] frac_q, frac_d;
  logic [4:0]  sq_cnt_q, sq_cnt_d;
  logic [35:0] coef_mag_q, coef_mag_d;
  logic        coef_neg_q, coef_neg_d;
  logic [35:0] ma_q, ma_d;
  logic [31:0] mb_q, mb_d;
  logic        mneg_q, mneg_d, msh8_q, msh8_d, mln_q, mln_d;
  logic [67:0] acc_q, acc_d;
  logic [35:0] t_mag_q, t_mag_d;
  logic        t_neg_q, t_neg_d;
  logic [7:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [31:0] thi_q, thi_d, diff_q, diff_d;
  logic        wz_q, wz_d;
  logic [39:0] w_q, w_d;

  // output register
  logic        res_valid_q, res_valid_d;
  logic [47:0] res_ld_q, res_ld_d;
  logic [1:0]  res_st_q, res_st_d;

  // table memory
  logic [31:0] tbl_mem_q [TABLE_DEPTH];
  logic [31:0] rd_q;
  logic        rd_oor_q;
  logic        rd_en;
  logic [7:0]  rd_idx;
  logic        wr_en;
  logic [31:0] tab;

  // shared multiplier
  logic        mul_en;
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic        req_acc;
  logic [31:0] sq_sel;
  logic [10:0] c_mag;
  logic        c_neg;

  rlde_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign cfg_i.ready = 1'b1;

  assign res_o.valid       = res_valid_q;
  assign res_o.log_density = res_ld_q;
  assign res_o.status      = res_st_q;

  assign tab    = rd_oor_q ? 32'd0 : rd_q;
  assign sq_sel = prod[63] ? prod[63:32] : prod[62:31];
  assign c_neg  = (dim_q == 11'd0);
  assign c_mag  = c_neg ? 11'd1 : dim_q - 11'd1;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_UNSET;
      dim_q      <= 11'd1;
      logc_q     <= '0;
      pexp_q     <= '0;
      lbound_q   <= '0;
      ubound_q   <= '0;
      tentries_q <= 8'd1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_MODE:          mode_q     <= cfg_i.data[2:0];
        CFG_DIMENSION:     dim_q      <= cfg_i.data[10:0];
        CFG_LOG_CONSTANT:  logc_q     <= cfg_i.data[47:0];
        CFG_POWER_EXP:     pexp_q     <= cfg_i.data[31:0];
        CFG_LOWER_BOUND:   lbound_q   <= cfg_i.data[31:0];
        CFG_UPPER_BOUND:   ubound_q   <= cfg_i.data[31:0];
        CFG_TABLE_ENTRIES: tentries_q <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  // table memory: one write port, one registered read port
  assign wr_en = req_acc && (req_i.req_type == REQ_WRITE) &&
                 (32'(req_i.table_index) < TABLE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem_q[AW'(req_i.table_index)] <= req_i.table_value;
    end
    if (rd_en) begin
      rd_q <= tbl_mem_q[AW'(rd_idx)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_oor_q <= 1'b0;
    end else if (rd_en) begin
      rd_oor_q <= !(32'(rd_idx) < TABLE_DEPTH);
    end
  end

  // multiplier operand select
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_HSQ: begin
        mul_en = 1'b1;
        mul_a  = r_q;
        mul_b  = r_q;
      end
      S_TW: begin
        mul_en = 1'b1;
        mul_a  = 32'(tentries_q);
        mul_b  = diff_q;
      end
      S_SQ: begin
        mul_en = (sq_cnt_q < SQ_STEPS);
        mul_a  = (sq_cnt_q == 5'd0) ? x_q[39:8] : sq_sel;
        mul_b  = (sq_cnt_q == 5'd0) ? x_q[39:8] : sq_sel;
      end
      S_MLO: begin
        mul_en = 1'b1;
        mul_a  = ma_q[31:0];
        mul_b  = mb_q;
      end
      S_MHI: begin
        mul_en = 1'b1;
        mul_a  = {28'd0, ma_q[35:32]};
        mul_b  = mb_q;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    logic [35:0] kk, nn, lmag;
    logic [67:0] rnd;
    logic [8:0]  msum;
    logic        eff_neg;
    logic [5:0]  e_hi;
    logic [4:0]  e_lo;

    state_d    = state_q;
    r_d        = r_q;
    val_d      = val_q;
    status_d   = status_q;
    pinf_d     = pinf_q;
    ph_d       = ph_q;
    x_d        = x_q;
    p_d        = p_q;
    frac_d     = frac_q;
    sq_cnt_d   = sq_cnt_q;
    coef_mag_d = coef_mag_q;
    coef_neg_d = coef_neg_q;
    ma_d       = ma_q;
    mb_d       = mb_q;
    mneg_d     = mneg_q;
    msh8_d     = msh8_q;
    mln_d      = mln_q;
    acc_d      = acc_q;
    t_mag_d    = t_mag_q;
    t_neg_d    = t_neg_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    thi_d      = thi_q;
    diff_d     = diff_q;
    wz_d       = wz_q;
    w_d        = w_q;
    res_valid_d = res_valid_q;
    res_ld_d   = res_ld_q;
    res_st_d   = res_st_q;
    rd_en      = 1'b0;
    rd_idx     = '0;

    kk      = {4'd0, pexp_q};
    nn      = {1'b0, dim_q, 24'd0};
    lmag    = '0;
    rnd     = '0;
    msum    = {1'b0, lo_q} + {1'b0, hi_q};
    eff_neg = t_neg_q ^ (ph_q != PH_POW);
    e_hi    = p_q - 6'd24;
    e_lo    = 5'(6'd24 - p_q);

    // drop the word once taken
    if (res_valid_q && res_o.ready) begin
      res_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (req_acc && (req_i.req_type == REQ_EVAL)) begin
          r_d      = req_i.radius;
          val_d    = {{2{logc_q[47]}}, logc_q};
          status_d = ST_OK;
          pinf_d   = 1'b0;
          state_d  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        unique case (mode_q) inside
          MODE_GAUSS: begin
            ph_d    = PH_GAUSS;
            state_d = S_HSQ;
          end
          MODE_TGAUSS: begin
            ph_d = PH_GAUSS;
            if (r_q < lbound_q || r_q > ubound_q) begin
              status_d = ST_OUTSIDE;
              state_d  = S_DONE;
            end else begin
              state_d = S_HSQ;
            end
          end
          MODE_UNIFORM: begin
            if (r_q > ONE_Q24) status_d = ST_OUTSIDE;
            state_d = S_DONE;
          end
          MODE_POWER, MODE_TPOWER: begin
            if (r_q > ONE_Q24 || (mode_q == MODE_TPOWER && r_q < lbound_q)) begin
              status_d = ST_OUTSIDE;
              state_d  = S_DONE;
            end else begin
              state_d = S_COEF;
            end
          end
          MODE_TABLE: begin
            rd_en   = 1'b1;
            rd_idx  = tentries_q;
            lo_d    = '0;
            hi_d    = tentries_q;
            state_d = S_TCHK;
          end
          default: begin
            status_d = ST_UNSET;
            state_d  = S_DONE;
          end
        endcase
      end
      S_COEF: begin
        // coefficient k - n, kept as sign and magnitude
        coef_neg_d = (kk < nn);
        coef_mag_d = (kk < nn) ? nn - kk : kk - nn;
        if (r_q == 32'd0) begin
          if (kk < nn) pinf_d = 1'b1;
          else if (kk != nn) status_d = ST_OUTSIDE;
          state_d = S_DONE;
        end else begin
          x_d     = {8'd0, r_q};
          p_d     = 6'd39;
          ph_d    = PH_POW;
          state_d = S_NORM;
        end
      end
      S_HSQ: state_d = S_HSQ2;
      S_HSQ2: begin
        t_mag_d = 36'(({1'b0, prod} + 65'h1_0000_0000) >> 33);
        t_neg_d = 1'b0;
        state_d = S_ACC;
      end
      S_TCHK: begin
        if (r_q > tab) begin
          status_d = ST_OUTSIDE;
          state_d  = S_DONE;
        end else begin
          thi_d   = tab;
          state_d = S_TSRCH;
        end
      end
      S_TSRCH: begin
        rd_en = 1'b1;
        if (hi_q - lo_q > 8'd1) begin
          mid_d   = msum[8:1];
          rd_idx  = msum[8:1];
          state_d = S_TCMP;
        end else begin
          rd_idx  = lo_q;
          state_d = S_TLO;
        end
      end
      S_TCMP: begin
        if (r_q > tab) begin
          lo_d = mid_q;
        end else begin
          hi_d  = mid_q;
          thi_d = tab;
        end
        state_d = S_TSRCH;
      end
      S_TLO: begin
        wz_d    = (thi_q <= tab);
        diff_d  = thi_q - tab;
        state_d = S_TW;
      end
      S_TW: begin
        if (wz_q) begin
          status_d = ST_OUTSIDE;
          state_d  = S_DONE;
        end else begin
          state_d = S_TW2;
        end
      end
      S_TW2: begin
        w_d = prod[39:0];
        p_d = 6'd39;
        if (r_q == 32'd0) begin
          if (c_neg) begin
            status_d = ST_OUTSIDE;
            state_d  = S_DONE;
          end else if (dim_q != 11'd1) begin
            pinf_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            x_d     = prod[39:0];
            ph_d    = PH_TABW;
            state_d = S_NORM;
          end
        end else begin
          x_d     = {8'd0, r_q};
          ph_d    = PH_TABR;
          state_d = S_NORM;
        end
      end
      S_NORM: begin
        // advance toward a leading one at bit 39
        if (x_q[39]) begin
          sq_cnt_d = '0;
          state_d  = S_SQ;
        end else if (x_q[39:32] == 8'd0) begin
          x_d = {x_q[31:0], 8'd0};
          p_d = p_q - 6'd8;
        end else begin
          x_d = {x_q[38:0], 1'b0};
          p_d = p_q - 6'd1;
        end
      end
      S_SQ: begin
        if (sq_cnt_q != 5'd0) begin
          frac_d = {frac_q[26:0], prod[63]};
        end
        if (sq_cnt_q == SQ_STEPS) begin
          state_d = S_LNPREP;
        end else begin
          sq_cnt_d = sq_cnt_q + 5'd1;
        end
      end
      S_LNPREP: begin
        // log2 as sign and magnitude, Q.28
        if (p_q >= 6'd24) begin
          lmag   = {4'd0, e_hi[3:0], frac_q};
          mneg_d = 1'b0;
        end else begin
          lmag   = {3'd0, e_lo, 28'd0} - {8'd0, frac_q};
          mneg_d = 1'b1;
        end
        ma_d    = lmag;
        mb_d    = LN2_Q28;
        msh8_d  = 1'b0;
        mln_d   = 1'b1;
        state_d = S_MLO;
      end
      S_MLO: state_d = S_MHI;
      S_MHI: begin
        acc_d   = {4'd0, prod};
        state_d = S_MSUM;
      end
      S_MSUM: begin
        acc_d   = acc_q + {prod[35:0], 32'd0};
        state_d = S_ROUND;
      end
      S_ROUND: begin
        // round half away from zero on the magnitude
        if (msh8_q) rnd = (acc_q + 68'd128) >> 8;
        else        rnd = (acc_q + 68'h8000_0000) >> 32;
        t_mag_d = rnd[35:0];
        t_neg_d = mneg_q;
        state_d = mln_q ? S_TERM : S_ACC;
      end
      S_TERM: begin
        mln_d = 1'b0;
        case (ph_q)
          PH_POW: begin
            ma_d   = coef_mag_q;
            mb_d   = t_mag_q[31:0];
            mneg_d = coef_neg_q ^ t_neg_q;
            msh8_d = 1'b0;
          end
          PH_TABR: begin
            ma_d   = {25'd0, c_mag};
            mb_d   = t_mag_q[31:0];
            mneg_d = c_neg ^ t_neg_q;
            msh8_d = 1'b1;
          end
          default: begin
            ma_d   = t_mag_q;
            mb_d   = 32'd1;
            mneg_d = t_neg_q;
            msh8_d = 1'b1;
          end
        endcase
        state_d = S_MLO;
      end
      S_ACC: begin
        if (eff_neg) val_d = val_q - $signed({14'd0, t_mag_q});
        else         val_d = val_q + $signed({14'd0, t_mag_q});
        if (ph_q == PH_TABR) begin
          x_d     = w_q;
          p_d     = 6'd39;
          ph_d    = PH_TABW;
          state_d = S_NORM;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!res_valid_q || res_o.ready) begin
          res_valid_d = 1'b1;
          res_st_d    = status_q;
          if (status_q != ST_OK)  res_ld_d = '0;
          else if (pinf_q)        res_ld_d = LD_MAX;
          else if (val_q > VMAX)  res_ld_d = LD_MAX;
          else if (val_q < VMIN)  res_ld_d = LD_MIN;
          else                    res_ld_d = val_q[47:0];
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q        <= r_d;
    val_q      <= val_d;
    status_q   <= status_d;
    pinf_q     <= pinf_d;
    ph_q       <= ph_d;
    x_q        <= x_d;
    p_q        <= p_d;
    frac_q     <= frac_d;
    sq_cnt_q   <= sq_cnt_d;
    coef_mag_q <= coef_mag_d;
    coef_neg_q <= coef_neg_d;
    ma_q       <= ma_d;
    mb_q       <= mb_d;
    mneg_q     <= mneg_d;
    msh8_q     <= msh8_d;
    mln_q      <= mln_d;
    acc_q      <= acc_d;
    t_mag_q    <= t_mag_d;
    t_neg_q    <= t_neg_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    thi_q      <= thi_d;
    diff_q     <= diff_d;
    wz_q       <= wz_d;
    w_q        <= w_d;
    res_ld_q   <= res_ld_d;
    res_st_q   <= res_st_d;
  end

  `ASSERT_P(a_valid_from_done, $rose(res_o.valid) |-> $past(state_q) == S_DONE)
  `ASSERT_NR(a_err_zero, (res_o.valid && res_o.status != ST_OK) |-> res_o.log_density == '0)
  `ASSERT_P(a_sq_normalized, (state_q == S_SQ) |-> x_q[39])
  `ASSERT_P(a_search_order, (state_q == S_TSRCH) |-> lo_q <= hi_q)

endmodule
